### src/tmrq_pkg.sv
// package for the timed memory with response queue
// holds transaction structs, op and result codes, state types and the time compare
// no dependencies
package tmrq_pkg;

	localparam logic [2:0] OP_TICK  = 3'd0;
	localparam logic [2:0] OP_READ  = 3'd1;
	localparam logic [2:0] OP_WRITE = 3'd2;
	localparam logic [2:0] OP_SWAP  = 3'd3;
	localparam logic [2:0] OP_CSWAP = 3'd4;

	localparam logic [2:0] KIND_ACCEPTED = 3'd0;
	localparam logic [2:0] KIND_REFUSED  = 3'd1;
	localparam logic [2:0] KIND_RANGE    = 3'd2;
	localparam logic [2:0] KIND_RETRY    = 3'd3;
	localparam logic [2:0] KIND_RESPONSE = 3'd4;
	localparam logic [2:0] KIND_FULL     = 3'd5;

	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] CFG_LATENCY        = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_TICKS_PER_BYTE = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_RANGE_BASE     = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_RANGE_BYTES    = 2'd3;

	// command queue between front and back, power of two
	localparam int FIFO_DEPTH = 2;

	typedef struct packed {
		logic [2:0]  op;
		logic [31:0] address;
		logic [3:0]  size;
		logic [63:0] wdata;
		logic [7:0]  byte_enable;
		logic        masked;
		logic        needs_response;
		logic [63:0] compare_value;
		logic [15:0] receive_delay;
		logic        resp_accept;
	} req_t;

	typedef struct packed {
		logic [2:0]  kind;
		logic [31:0] rsp_address;
		logic [63:0] rsp_data;
		logic        last;
	} rsp_t;

	typedef struct packed {
		logic [2:0]  op;
		logic [31:0] off;
		logic [3:0]  size;
		logic [63:0] wdata;
		logic [7:0]  be;
		logic        masked;
		logic        needs_response;
		logic [63:0] cmp;
		logic [31:0] ready;
		logic [31:0] addr;
	} cmd_t;

	typedef struct packed {
		logic        clearing;
		logic        idle;
		logic [31:0] head_ready;
		logic [31:0] head_addr;
		logic [63:0] head_data;
	} bk_stat_t;

	typedef enum logic [1:0] {F_IDLE, F_EVAL, F_POP} front_state_t;

	typedef enum logic [2:0] {B_CLEAR, B_IDLE, B_READ, B_DECIDE, B_WRITE, B_INSERT}
		back_state_t;

	// wrap-aware a <= b
	function automatic logic time_le(logic [31:0] a, logic [31:0] b);
		logic [31:0] d;
		d = b - a;
		return !d[31];
	endfunction

endpackage

### src/timed_memory_with_response_queue_top.sv
// top level of the timed memory with response queue
// depends on tmrq_pkg, tmrq_front, tmrq_fifo, tmrq_back, tmrq_ram
//
// Usage: a transaction (request or tick) is taken at a clock edge with start high and
// busy low; op 0 is a tick that advances time and may release a retry and a response.
// Results appear on rsp with done high for one cycle each; the receiver cannot stall.
// A request with op 1 to 4 gives a single result, ops above 4 give none; the result
// is decided in the evaluate state and registered onto rsp. A tick gives its results
// once earlier work has finished, a retry before a response when it has both.
// The back end carries an accepted access out a byte a cycle through the single
// memory port: it reads every byte, writes them back for a write, a swap or a matching
// compare-swap, and walks a response back into the ready-time ordered queue when one
// is needed. The command queue lets the front take further requests meanwhile,
// while it has room; a tick waits for the back to settle.
// After reset the memory is cleared one byte a cycle with busy high;
// configuration writes are taken at any time through cfg_we, cfg_index, cfg_wdata.
module timed_memory_with_response_queue_top #(
	parameter int MEM_BYTES        = 65536,
	parameter int QUEUE_DEPTH      = 16,
	parameter int MAX_ACCESS_BYTES = 8
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	input  tmrq_pkg::req_t                 req,
	output logic                           busy,
	output logic                           done,
	output tmrq_pkg::rsp_t                 rsp,
	input  logic                           cfg_we,
	input  logic [tmrq_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [31:0]                    cfg_wdata
);

	tmrq_pkg::cmd_t     cmd_in, cmd_out;
	tmrq_pkg::bk_stat_t stat;
	logic push, cmd_pop, fifo_empty, fifo_full, rsp_pop;

	tmrq_front #(
		.MEM_BYTES        (MEM_BYTES),
		.QUEUE_DEPTH      (QUEUE_DEPTH),
		.MAX_ACCESS_BYTES (MAX_ACCESS_BYTES)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.req        (req),
		.busy       (busy),
		.done       (done),
		.rsp        (rsp),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_wdata  (cfg_wdata),
		.fifo_full  (fifo_full),
		.fifo_empty (fifo_empty),
		.push       (push),
		.cmd        (cmd_in),
		.rsp_pop    (rsp_pop),
		.stat       (stat)
	);

	tmrq_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.din    (cmd_in),
		.pop    (cmd_pop),
		.dout   (cmd_out),
		.empty  (fifo_empty),
		.full   (fifo_full)
	);

	tmrq_back #(
		.MEM_BYTES   (MEM_BYTES),
		.QUEUE_DEPTH (QUEUE_DEPTH)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.fifo_empty (fifo_empty),
		.cmd        (cmd_out),
		.cmd_pop    (cmd_pop),
		.rsp_pop    (rsp_pop),
		.stat       (stat)
	);

endmodule

### src/tmrq_ram.sv
// generic single-port ram with registered read
// no dependencies
module tmrq_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic                     we,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		rdata <= mem_q[addr];
	end

endmodule

### src/tmrq_fifo.sv
// short command queue between the front and the back
// depends on tmrq_pkg
module tmrq_fifo (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  tmrq_pkg::cmd_t din,
	input  logic          pop,
	output tmrq_pkg::cmd_t dout,
	output logic          empty,
	output logic          full
);

	localparam int PW = $clog2(tmrq_pkg::FIFO_DEPTH);
	localparam int CW = $clog2(tmrq_pkg::FIFO_DEPTH + 1);

	tmrq_pkg::cmd_t ent_q [tmrq_pkg::FIFO_DEPTH];
	logic [PW-1:0] wp_q, rp_q;
	logic [CW-1:0] cnt_q;

	assign empty = (cnt_q == '0);
	assign full  = (cnt_q == CW'(tmrq_pkg::FIFO_DEPTH));
	assign dout  = ent_q[rp_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wp_q <= wp_q + 1'b1;
			end
			if (pop) begin
				rp_q <= rp_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wp_q] <= din;
		end
	end

endmodule

### src/tmrq_front.sv
// front end: takes transactions, keeps time, busy and retry state, classifies requests
// and drives the result port; depends on tmrq_pkg
module tmrq_front #(
	parameter int MEM_BYTES        = 65536,
	parameter int QUEUE_DEPTH      = 16,
	parameter int MAX_ACCESS_BYTES = 8
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             start,
	input  tmrq_pkg::req_t                   req,
	output logic                             busy,
	output logic                             done,
	output tmrq_pkg::rsp_t                   rsp,
	input  logic                             cfg_we,
	input  logic [tmrq_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [31:0]                      cfg_wdata,
	input  logic                             fifo_full,
	input  logic                             fifo_empty,
	output logic                             push,
	output tmrq_pkg::cmd_t                   cmd,
	output logic                             rsp_pop,
	input  tmrq_pkg::bk_stat_t               stat
);

	localparam int QCW = $clog2(QUEUE_DEPTH + 1);
	localparam logic [32:0] MEM_LIM = 33'(MEM_BYTES);

	tmrq_pkg::front_state_t st_q, st_d;
	tmrq_pkg::req_t item_q;
	logic [31:0] now_q, busy_until_q, base_q;
	logic        blk_busy_q, retry_q;
	logic [QCW-1:0] qc_q;
	logic [15:0] lat_q;
	logic [7:0]  tpb_q;
	logic [16:0] rbytes_q;
	logic        done_q;
	tmrq_pkg::rsp_t rsp_q;

	logic accept;
	logic [31:0] now_n, off, busy_until_n;
	logic [32:0] end_off, limit;
	logic [11:0] dur;
	logic expire, give_retry, do_pop, bad, qfull, tick_wait;
	logic res_v, adv, clr_busy, set_busy, set_retry, qc_inc, qc_dec;
	tmrq_pkg::rsp_t res;

	assign busy   = (st_q != tmrq_pkg::F_IDLE) || fifo_full || stat.clearing;
	assign accept = start && !busy;
	assign done   = done_q;
	assign rsp    = rsp_q;

	assign now_n        = now_q + 32'd1;
	assign off          = item_q.address - base_q;
	assign end_off      = {1'b0, off} + 33'(item_q.size);
	assign limit        = (33'(rbytes_q) < MEM_LIM) ? 33'(rbytes_q) : MEM_LIM;
	assign dur          = 12'(item_q.size) * 12'(tpb_q);
	assign busy_until_n = now_q + 32'(dur);
	assign expire       = blk_busy_q && tmrq_pkg::time_le(busy_until_q, now_n);
	assign give_retry   = expire && retry_q;
	assign do_pop       = (qc_q != '0) && item_q.resp_accept
		&& tmrq_pkg::time_le(stat.head_ready, now_n);
	assign bad = (item_q.size == 4'd0) || (item_q.size > 4'(MAX_ACCESS_BYTES))
		|| (item_q.address < base_q) || (end_off > limit);
	assign qfull = item_q.needs_response && (qc_q >= QCW'(QUEUE_DEPTH));
	// a tick looks at the queue head, so the back must have settled
	assign tick_wait = !(fifo_empty && stat.idle);

	always_comb begin
		cmd.op             = item_q.op;
		cmd.off            = off;
		cmd.size           = item_q.size;
		cmd.wdata          = item_q.wdata;
		cmd.be             = item_q.byte_enable;
		cmd.masked         = item_q.masked;
		cmd.needs_response = item_q.needs_response;
		cmd.cmp            = item_q.compare_value;
		cmd.ready          = now_q + 32'(item_q.receive_delay) + 32'(lat_q);
		cmd.addr           = item_q.address;
	end

	always_comb begin
		st_d      = st_q;
		res_v     = 1'b0;
		res       = '0;
		adv       = 1'b0;
		clr_busy  = 1'b0;
		set_busy  = 1'b0;
		set_retry = 1'b0;
		push      = 1'b0;
		rsp_pop   = 1'b0;
		qc_inc    = 1'b0;
		qc_dec    = 1'b0;
		unique case (st_q)
			tmrq_pkg::F_IDLE: begin
				if (accept) begin
					st_d = tmrq_pkg::F_EVAL;
				end
			end
			tmrq_pkg::F_EVAL: begin
				if (item_q.op == tmrq_pkg::OP_TICK) begin
					if (!tick_wait) begin
						st_d     = tmrq_pkg::F_IDLE;
						adv      = 1'b1;
						clr_busy = expire;
						if (give_retry) begin
							res_v     = 1'b1;
							res.kind  = tmrq_pkg::KIND_RETRY;
							res.last  = !do_pop;
							if (do_pop) begin
								st_d = tmrq_pkg::F_POP;
							end
						end else if (do_pop) begin
							res_v           = 1'b1;
							res.kind        = tmrq_pkg::KIND_RESPONSE;
							res.rsp_address = stat.head_addr;
							res.rsp_data    = stat.head_data;
							res.last        = 1'b1;
							rsp_pop         = 1'b1;
							qc_dec          = 1'b1;
						end
					end
				end else if (item_q.op > tmrq_pkg::OP_CSWAP) begin
					st_d = tmrq_pkg::F_IDLE;
				end else begin
					st_d            = tmrq_pkg::F_IDLE;
					res_v           = 1'b1;
					res.rsp_address = item_q.address;
					res.last        = 1'b1;
					priority if (retry_q) begin
						res.kind = tmrq_pkg::KIND_REFUSED;
					end else if (blk_busy_q) begin
						res.kind  = tmrq_pkg::KIND_REFUSED;
						set_retry = 1'b1;
					end else if (bad) begin
						res.kind = tmrq_pkg::KIND_RANGE;
					end else if (qfull) begin
						res.kind = tmrq_pkg::KIND_FULL;
					end else begin
						res.kind = tmrq_pkg::KIND_ACCEPTED;
						push     = 1'b1;
						qc_inc   = item_q.needs_response;
						set_busy = (dur != 12'd0);
					end
				end
			end
			tmrq_pkg::F_POP: begin
				st_d            = tmrq_pkg::F_IDLE;
				res_v           = 1'b1;
				res.kind        = tmrq_pkg::KIND_RESPONSE;
				res.rsp_address = stat.head_addr;
				res.rsp_data    = stat.head_data;
				res.last        = 1'b1;
				rsp_pop         = 1'b1;
				qc_dec          = 1'b1;
			end
			default: begin
				st_d = tmrq_pkg::F_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q         <= tmrq_pkg::F_IDLE;
			now_q        <= '0;
			blk_busy_q   <= 1'b0;
			busy_until_q <= '0;
			retry_q      <= 1'b0;
			qc_q         <= '0;
			lat_q        <= 16'd30;
			tpb_q        <= '0;
			base_q       <= '0;
			rbytes_q     <= 17'h10000;
			done_q       <= 1'b0;
			rsp_q        <= '0;
		end else begin
			st_q   <= st_d;
			done_q <= res_v;
			rsp_q  <= res;
			if (adv) begin
				now_q <= now_n;
			end
			if (clr_busy) begin
				blk_busy_q <= 1'b0;
				retry_q    <= 1'b0;
			end
			if (set_busy) begin
				blk_busy_q   <= 1'b1;
				busy_until_q <= busy_until_n;
			end
			if (set_retry) begin
				retry_q <= 1'b1;
			end
			if (qc_inc) begin
				qc_q <= qc_q + 1'b1;
			end else if (qc_dec) begin
				qc_q <= qc_q - 1'b1;
			end
			if (cfg_we) begin
				unique case (cfg_index)
					tmrq_pkg::CFG_LATENCY:        lat_q    <= cfg_wdata[15:0];
					tmrq_pkg::CFG_TICKS_PER_BYTE: tpb_q    <= cfg_wdata[7:0];
					tmrq_pkg::CFG_RANGE_BASE:     base_q   <= cfg_wdata;
					tmrq_pkg::CFG_RANGE_BYTES:    rbytes_q <= cfg_wdata[16:0];
					default: ;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_q <= req;
		end
	end

endmodule

### src/tmrq_back.sv
// back end: clears the byte memory after reset, carries out reads, writes and swaps
// a byte a cycle, and keeps the ordered response queue; depends on tmrq_pkg, tmrq_ram
module tmrq_back #(
	parameter int MEM_BYTES   = 65536,
	parameter int QUEUE_DEPTH = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               fifo_empty,
	input  tmrq_pkg::cmd_t     cmd,
	output logic               cmd_pop,
	input  logic               rsp_pop,
	output tmrq_pkg::bk_stat_t stat
);

	localparam int AW  = $clog2(MEM_BYTES);
	localparam int QIW = $clog2(QUEUE_DEPTH);
	localparam int QCW = $clog2(QUEUE_DEPTH + 1);
	localparam logic [AW-1:0] LAST_ADDR = AW'(MEM_BYTES - 1);

	tmrq_pkg::back_state_t st_q, st_d;
	tmrq_pkg::cmd_t cur_q;
	logic [3:0]     idx_q;
	logic [AW-1:0]  clr_q;
	logic [63:0]    old_q;
	logic [QCW-1:0] qn_q;
	logic [QIW-1:0] pos_q, pm1;
	logic [31:0] q_ready_q [QUEUE_DEPTH];
	logic [31:0] q_addr_q  [QUEUE_DEPTH];
	logic [63:0] q_data_q  [QUEUE_DEPTH];

	logic [AW-1:0] ram_addr;
	logic          ram_we;
	logic [7:0]    ram_wdata, ram_rdata;
	logic [63:0]   cmpmask, new_data;
	logic [2:0]    idx_m1;
	logic          repl, ins_start, swap, capture;

	tmrq_ram #(.WIDTH(8), .DEPTH(MEM_BYTES)) u_ram (
		.clk   (clk),
		.addr  (ram_addr),
		.we    (ram_we),
		.wdata (ram_wdata),
		.rdata (ram_rdata)
	);

	assign idx_m1   = 3'(idx_q - 4'd1);
	assign pm1      = pos_q - 1'b1;
	assign new_data = (cur_q.op == tmrq_pkg::OP_WRITE) ? 64'd0 : old_q;

	always_comb begin
		for (int j = 0; j < 8; j++) begin
			cmpmask[j*8 +: 8] = (4'(j) < cur_q.size) ? 8'hFF : 8'h00;
		end
		unique case (cur_q.op)
			tmrq_pkg::OP_WRITE, tmrq_pkg::OP_SWAP: repl = 1'b1;
			tmrq_pkg::OP_CSWAP: repl = (((old_q ^ cur_q.cmp) & cmpmask) == 64'd0);
			default: repl = 1'b0;
		endcase
	end

	assign stat.clearing   = (st_q == tmrq_pkg::B_CLEAR);
	assign stat.idle       = (st_q == tmrq_pkg::B_IDLE);
	assign stat.head_ready = q_ready_q[0];
	assign stat.head_addr  = q_addr_q[0];
	assign stat.head_data  = q_data_q[0];

	always_comb begin
		st_d      = st_q;
		cmd_pop   = 1'b0;
		ram_addr  = cur_q.off[AW-1:0] + AW'(idx_q);
		ram_we    = 1'b0;
		ram_wdata = cur_q.wdata[{idx_q[2:0], 3'b000} +: 8];
		ins_start = 1'b0;
		swap      = 1'b0;
		capture   = 1'b0;
		unique case (st_q)
			tmrq_pkg::B_CLEAR: begin
				ram_addr  = clr_q;
				ram_we    = 1'b1;
				ram_wdata = 8'd0;
				if (clr_q == LAST_ADDR) begin
					st_d = tmrq_pkg::B_IDLE;
				end
			end
			tmrq_pkg::B_IDLE: begin
				if (!fifo_empty && !rsp_pop) begin
					cmd_pop = 1'b1;
					st_d    = tmrq_pkg::B_READ;
				end
			end
			tmrq_pkg::B_READ: begin
				// read data arrives in the cycle after its address
				capture = (idx_q != 4'd0);
				if (idx_q == cur_q.size) begin
					st_d = tmrq_pkg::B_DECIDE;
				end
			end
			tmrq_pkg::B_DECIDE: begin
				if (repl) begin
					st_d = tmrq_pkg::B_WRITE;
				end else if (cur_q.needs_response) begin
					ins_start = 1'b1;
					st_d      = tmrq_pkg::B_INSERT;
				end else begin
					st_d = tmrq_pkg::B_IDLE;
				end
			end
			tmrq_pkg::B_WRITE: begin
				ram_we = (cur_q.op != tmrq_pkg::OP_WRITE) || !cur_q.masked
					|| cur_q.be[idx_q[2:0]];
				if (idx_q == cur_q.size - 4'd1) begin
					if (cur_q.needs_response) begin
						ins_start = 1'b1;
						st_d      = tmrq_pkg::B_INSERT;
					end else begin
						st_d = tmrq_pkg::B_IDLE;
					end
				end
			end
			tmrq_pkg::B_INSERT: begin
				// walk back one entry a cycle until the head, an entry not later, or a same-address entry
				if (pos_q == '0 || tmrq_pkg::time_le(q_ready_q[pm1], cur_q.ready)
					|| q_addr_q[pm1] == cur_q.addr) begin
					st_d = tmrq_pkg::B_IDLE;
				end else begin
					swap = 1'b1;
				end
			end
			default: begin
				st_d = tmrq_pkg::B_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q  <= tmrq_pkg::B_CLEAR;
			clr_q <= '0;
			idx_q <= '0;
			qn_q  <= '0;
			pos_q <= '0;
		end else begin
			st_q <= st_d;
			if (st_q == tmrq_pkg::B_CLEAR) begin
				clr_q <= clr_q + 1'b1;
			end
			if (cmd_pop || st_d == tmrq_pkg::B_WRITE && st_q == tmrq_pkg::B_DECIDE) begin
				idx_q <= '0;
			end else if (st_q == tmrq_pkg::B_READ || st_q == tmrq_pkg::B_WRITE) begin
				idx_q <= idx_q + 4'd1;
			end
			if (ins_start) begin
				qn_q  <= qn_q + 1'b1;
				pos_q <= qn_q[QIW-1:0];
			end else if (swap) begin
				pos_q <= pm1;
			end else if (rsp_pop && st_q == tmrq_pkg::B_IDLE) begin
				qn_q <= qn_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_pop) begin
			cur_q <= cmd;
			old_q <= '0;
		end else if (capture) begin
			old_q[{idx_m1, 3'b000} +: 8] <= ram_rdata;
		end
		if (rsp_pop && st_q == tmrq_pkg::B_IDLE) begin
			for (int i = 0; i < QUEUE_DEPTH - 1; i++) begin
				q_ready_q[i] <= q_ready_q[i+1];
				q_addr_q[i]  <= q_addr_q[i+1];
				q_data_q[i]  <= q_data_q[i+1];
			end
		end else if (ins_start) begin
			q_ready_q[qn_q[QIW-1:0]] <= cur_q.ready;
			q_addr_q[qn_q[QIW-1:0]]  <= cur_q.addr;
			q_data_q[qn_q[QIW-1:0]]  <= new_data;
		end else if (swap) begin
			q_ready_q[pos_q] <= q_ready_q[pm1];
			q_addr_q[pos_q]  <= q_addr_q[pm1];
			q_data_q[pos_q]  <= q_data_q[pm1];
			q_ready_q[pm1]   <= cur_q.ready;
			q_addr_q[pm1]    <= cur_q.addr;
			q_data_q[pm1]    <= new_data;
		end
	end

endmodule

### tb/tmrq_scoreboard.sv
// scoreboard for the timed memory with response queue: predicts every result and checks it
// depends on tmrq_pkg; snoops the request, result and configuration ports of the block
module tmrq_scoreboard (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	input  tmrq_pkg::req_t                 req,
	input  logic                           busy,
	input  logic                           done,
	input  tmrq_pkg::rsp_t                 rsp,
	input  logic                           cfg_we,
	input  logic [tmrq_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [31:0]                    cfg_wdata,
	output int                             fails,
	output int                             pending
);

	localparam int MEM_SIZE = 65536;
	localparam int DEPTH    = 16;

	logic [7:0]  mem_img [0:MEM_SIZE-1];
	logic [31:0] clock_now;
	logic        engaged;
	logic [31:0] engaged_until;
	logic        retry_owed;
	logic [31:0] q_ready [0:DEPTH-1];
	logic [31:0] q_addr  [0:DEPTH-1];
	logic [63:0] q_data  [0:DEPTH-1];
	int          q_count;

	logic [15:0] lat_cfg;
	logic [7:0]  tpb_cfg;
	logic [31:0] base_cfg;
	logic [16:0] bytes_cfg;

	tmrq_pkg::rsp_t expected_results [$];

	initial begin
		for (int i = 0; i < MEM_SIZE; i++) mem_img[i] = 8'h00;
		clock_now = '0;
		engaged = 1'b0;
		engaged_until = '0;
		retry_owed = 1'b0;
		q_count = 0;
		lat_cfg = 16'd30;
		tpb_cfg = 8'd0;
		base_cfg = '0;
		bytes_cfg = 17'd65536;
		fails = 0;
		pending = 0;
	end

	function automatic logic not_later(logic [31:0] a, logic [31:0] b);
		logic [31:0] d;
		d = b - a;
		return !d[31];
	endfunction

	function automatic void emit(logic [2:0] kind, logic [31:0] addr, logic [63:0] data);
		tmrq_pkg::rsp_t r;
		r.kind = kind;
		r.rsp_address = addr;
		r.rsp_data = data;
		r.last = 1'b0;
		expected_results.push_back(r);
	endfunction

	// ordered insert: walk back past later entries unless the address matches
	function automatic void enqueue_response(logic [31:0] ready, logic [31:0] addr,
		logic [63:0] data);
		int pos;
		pos = q_count;
		while (pos > 0) begin
			if (not_later(q_ready[pos-1], ready) || q_addr[pos-1] == addr) break;
			pos--;
		end
		for (int i = q_count; i > pos; i--) begin
			q_ready[i] = q_ready[i-1];
			q_addr[i]  = q_addr[i-1];
			q_data[i]  = q_data[i-1];
		end
		q_ready[pos] = ready;
		q_addr[pos]  = addr;
		q_data[pos]  = data;
		q_count++;
	endfunction

	function automatic void predict_results(tmrq_pkg::req_t r);
		int          first;
		int          lim;
		logic [31:0] off;
		logic [31:0] dur;
		logic [63:0] old;
		logic [63:0] m;
		logic        replace;
		first = expected_results.size();
		old = '0;
		if (r.op == tmrq_pkg::OP_TICK) begin
			clock_now++;
			if (engaged && not_later(engaged_until, clock_now)) begin
				engaged = 1'b0;
				if (retry_owed) begin
					retry_owed = 1'b0;
					emit(tmrq_pkg::KIND_RETRY, '0, '0);
				end
			end
			if (q_count > 0 && r.resp_accept && not_later(q_ready[0], clock_now)) begin
				emit(tmrq_pkg::KIND_RESPONSE, q_addr[0], q_data[0]);
				for (int i = 1; i < q_count; i++) begin
					q_ready[i-1] = q_ready[i];
					q_addr[i-1]  = q_addr[i];
					q_data[i-1]  = q_data[i];
				end
				q_count--;
			end
		end else if (r.op <= tmrq_pkg::OP_CSWAP) begin
			lim = (bytes_cfg < MEM_SIZE) ? int'(bytes_cfg) : MEM_SIZE;
			off = r.address - base_cfg;
			if (retry_owed) begin
				emit(tmrq_pkg::KIND_REFUSED, r.address, '0);
			end else if (engaged) begin
				retry_owed = 1'b1;
				emit(tmrq_pkg::KIND_REFUSED, r.address, '0);
			end else if (r.size == 0 || r.size > 8 || r.address < base_cfg ||
				longint'(off) + longint'(r.size) > longint'(lim)) begin
				emit(tmrq_pkg::KIND_RANGE, r.address, '0);
			end else if (r.needs_response && q_count >= DEPTH) begin
				emit(tmrq_pkg::KIND_FULL, r.address, '0);
			end else begin
				dur = 32'(r.size) * 32'(tpb_cfg);
				if (dur != 0) begin
					engaged = 1'b1;
					engaged_until = clock_now + dur;
				end
				for (int i = 0; i < r.size; i++) old[8*i +: 8] = mem_img[off + i];
				replace = 1'b1;
				if (r.op == tmrq_pkg::OP_CSWAP) begin
					m = (r.size >= 8) ? '1 : ((64'd1 << (8 * r.size)) - 64'd1);
					replace = ((old ^ r.compare_value) & m) == '0;
				end
				for (int i = 0; i < r.size; i++) begin
					if (r.op == tmrq_pkg::OP_WRITE) begin
						if (!r.masked || r.byte_enable[i])
							mem_img[off + i] = r.wdata[8*i +: 8];
					end else if (r.op != tmrq_pkg::OP_READ && replace) begin
						mem_img[off + i] = r.wdata[8*i +: 8];
					end
				end
				if (r.needs_response)
					enqueue_response(clock_now + 32'(r.receive_delay) + 32'(lat_cfg),
						r.address, (r.op == tmrq_pkg::OP_WRITE) ? 64'd0 : old);
				emit(tmrq_pkg::KIND_ACCEPTED, r.address, '0);
			end
		end
		if (expected_results.size() > first)
			expected_results[expected_results.size()-1].last = 1'b1;
	endfunction

	always @(posedge clk) begin
		tmrq_pkg::rsp_t want;
		if (arst_n) begin
			if (cfg_we) begin
				case (cfg_index)
					tmrq_pkg::CFG_LATENCY:        lat_cfg = cfg_wdata[15:0];
					tmrq_pkg::CFG_TICKS_PER_BYTE: tpb_cfg = cfg_wdata[7:0];
					tmrq_pkg::CFG_RANGE_BASE:     base_cfg = cfg_wdata;
					tmrq_pkg::CFG_RANGE_BYTES:    bytes_cfg = cfg_wdata[16:0];
					default: ;
				endcase
			end
			if (start && !busy) predict_results(req);
			if (done) begin
				if (expected_results.size() == 0) begin
					$display("%0t: unexpected result, expected none, actual %h", $realtime, rsp);
					fails++;
				end else begin
					want = expected_results[0];
					expected_results.delete(0);
					if (rsp !== want) begin
						$display("%0t: result mismatch, expected kind %0d addr %h data %h last %b",
							$realtime, want.kind, want.rsp_address, want.rsp_data, want.last);
						$display("%0t:                  actual kind %0d addr %h data %h last %b",
							$realtime, rsp.kind, rsp.rsp_address, rsp.rsp_data, rsp.last);
						fails++;
					end
				end
			end
			pending = expected_results.size();
		end
	end

endmodule

### tb/timed_memory_with_response_queue_top_test.sv
// testbench top for the timed memory with response queue: clock, reset, stimulus, verdict
// depends on tmrq_pkg, the block and tmrq_scoreboard, which does all prediction and checking
module timed_memory_with_response_queue_top_test;

	localparam int CYCLE_LIMIT = 3000000;

	logic                           clk;
	logic                           arst_n;
	logic                           start;
	tmrq_pkg::req_t                 req;
	logic                           busy;
	logic                           done;
	tmrq_pkg::rsp_t                 rsp;
	logic                           cfg_we;
	logic [tmrq_pkg::CFG_IDX_W-1:0] cfg_index;
	logic [31:0]                    cfg_wdata;
	int                             fails;
	int                             pending;
	int                             cycles = 0;
	int                             sent;
	int                             results_seen = 0;
	logic [31:0]                    cur_base;
	logic [16:0]                    cur_bytes;

	timed_memory_with_response_queue_top u_top (
		.clk(clk), .arst_n(arst_n), .start(start), .req(req), .busy(busy), .done(done),
		.rsp(rsp), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
	);

	tmrq_scoreboard u_scoreboard (
		.clk(clk), .arst_n(arst_n), .start(start), .req(req), .busy(busy), .done(done),
		.rsp(rsp), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
		.fails(fails), .pending(pending)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (done) results_seen <= results_seen + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("%0t: run timed out", $realtime);
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	function automatic tmrq_pkg::req_t make_req(logic [2:0] op, logic [31:0] addr,
		logic [3:0] size);
		tmrq_pkg::req_t r;
		r = '0;
		r.op = op;
		r.address = addr;
		r.size = size;
		r.needs_response = 1'b1;
		r.resp_accept = 1'b1;
		return r;
	endfunction

	function automatic tmrq_pkg::req_t rand_item(int tick_pct, int acc_pct, bit wide_delay);
		tmrq_pkg::req_t r;
		int   p;
		int   win;
		p = $urandom_range(0, 99);
		if (p < tick_pct) r.op = tmrq_pkg::OP_TICK;
		else if (p < tick_pct + 2) r.op = 3'($urandom_range(5, 7));
		else r.op = 3'($urandom_range(1, 4));
		win = (cur_bytes < 48) ? int'(cur_bytes) + 1 : 49;
		if ($urandom_range(0, 99) < 85) r.address = cur_base + 32'($urandom_range(0, win));
		else r.address = $urandom;
		if ($urandom_range(0, 9) != 0) r.size = 4'($urandom_range(1, 8));
		else r.size = 4'($urandom_range(0, 15));
		r.wdata = {$urandom, $urandom};
		r.byte_enable = 8'($urandom);
		r.masked = 1'($urandom);
		r.needs_response = $urandom_range(0, 3) != 0;
		p = $urandom_range(0, 9);
		if (p < 4) r.compare_value = '0;
		else if (p < 6) r.compare_value = '1;
		else r.compare_value = {$urandom, $urandom};
		r.receive_delay = wide_delay ? 16'($urandom) : 16'($urandom_range(0, 6));
		r.resp_accept = $urandom_range(0, 99) < acc_pct;
		return r;
	endfunction

	task automatic send(input tmrq_pkg::req_t r, input int gap);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req <= r;
		start <= 1'b1;
		@(posedge clk);
		while (busy) @(posedge clk);
		sent++;
	endtask

	// stop sending and let every outstanding transaction finish
	task automatic settle();
		start <= 1'b0;
		@(posedge clk);
		while (pending != 0 || busy) @(posedge clk);
		repeat (256) @(posedge clk);
	endtask

	task automatic write_reg(input logic [tmrq_pkg::CFG_IDX_W-1:0] idx,
		input logic [31:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic run_phase(input logic [15:0] lat, input logic [7:0] tpb,
		input logic [31:0] base, input logic [16:0] nbytes, input int count,
		input int tick_pct, input int acc_pct, input bit wide_delay);
		bit calm;
		settle();
		write_reg(tmrq_pkg::CFG_LATENCY, 32'(lat));
		write_reg(tmrq_pkg::CFG_TICKS_PER_BYTE, 32'(tpb));
		write_reg(tmrq_pkg::CFG_RANGE_BASE, base);
		write_reg(tmrq_pkg::CFG_RANGE_BYTES, 32'(nbytes));
		cur_base = base;
		cur_bytes = nbytes;
		calm = 1'b0;
		for (int k = 0; k < count; k++) begin
			if (k % 50 == 0) calm = $urandom_range(0, 3) == 0;
			if (k == count / 2) settle();
			send(rand_item(tick_pct, acc_pct, wide_delay), calm ? 0 : $urandom_range(0, 11));
		end
	endtask

	initial begin
		tmrq_pkg::req_t r;
		arst_n = 1'b0;
		start = 1'b0;
		req = '0;
		cfg_we = 1'b0;
		cfg_index = tmrq_pkg::CFG_LATENCY;
		cfg_wdata = '0;
		sent = 0;
		cur_base = '0;
		cur_bytes = 17'd65536;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		while (busy) @(posedge clk);
		write_reg(tmrq_pkg::CFG_LATENCY, 32'd2);

		// directed: byte order, masking, swaps, compare hit and miss, range edges
		r = make_req(tmrq_pkg::OP_WRITE, 32'd0, 4'd8); r.wdata = 64'h0123_4567_89ab_cdef;
		send(r, 0);
		send(make_req(tmrq_pkg::OP_READ, 32'd0, 4'd8), 0);
		r = make_req(tmrq_pkg::OP_WRITE, 32'd0, 4'd8); r.wdata = '1; r.masked = 1'b1;
		r.byte_enable = 8'h5a; send(r, 1);
		send(make_req(tmrq_pkg::OP_READ, 32'd0, 4'd4), 0);
		r = make_req(tmrq_pkg::OP_SWAP, 32'd4, 4'd4); r.wdata = 64'hdead_beef; send(r, 0);
		r = make_req(tmrq_pkg::OP_CSWAP, 32'd0, 4'd2);
		r.compare_value = 64'hffff_ffff_ffff_ffef;
		r.wdata = 64'h1111; send(r, 0);
		r = make_req(tmrq_pkg::OP_CSWAP, 32'd0, 4'd2); r.compare_value = 64'h1234; send(r, 2);
		send(make_req(tmrq_pkg::OP_READ, 32'd0, 4'd0), 0);
		send(make_req(tmrq_pkg::OP_READ, 32'd0, 4'd9), 0);
		send(make_req(tmrq_pkg::OP_READ, 32'd65535, 4'd2), 0);
		send(make_req(tmrq_pkg::OP_READ, 32'd65528, 4'd8), 0);
		send(make_req(tmrq_pkg::OP_READ, 32'hffff_ffff, 4'd1), 0);
		send(make_req(3'd7, 32'd0, 4'd1), 0);
		r = make_req(tmrq_pkg::OP_TICK, '0, '0); r.resp_accept = 1'b0; send(r, 0);
		for (int k = 0; k < 10; k++) send(make_req(tmrq_pkg::OP_TICK, '0, '0), k % 3);

		run_phase(16'd3, 8'd0, 32'd0, 17'd65536, 300, 45, 90, 1'b0);
		run_phase(16'd0, 8'd1, 32'h100, 17'd256, 250, 55, 80, 1'b0);
		run_phase(16'd17, 8'd3, 32'hffff_ff00, 17'h1ffff, 250, 55, 30, 1'b0);
		run_phase(16'd1, 8'd0, 32'h40, 17'd1, 150, 50, 90, 1'b0);
		run_phase(16'd5, 8'd255, 32'h8000, 17'd65535, 150, 75, 90, 1'b0);
		// long latency and long delays last, since those entries never drain
		run_phase(16'hffff, 8'd0, 32'd0, 17'd65536, 400, 50, 90, 1'b1);

		settle();
		$display("covered %0d transactions over six register settings, %0d results checked",
			sent, results_seen);
		if (fails == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule
